/* rtl/core/slt_pkg.sv */
package slt_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic insert;
    logic delete;
    logic found;
    logic rotate;
  } slt_ctl_t;

endpackage

/* rtl/core/slt_cell.sv */
module slt_cell (
  input  logic                            clk,
  input  slt_pkg::slt_ctl_t               ctl,
  input  logic                            occ,
  input  logic                            tail,
  input  logic                            left_lt,
  input  logic signed [slt_pkg::VAL_W-1:0] key,
  input  logic signed [slt_pkg::VAL_W-1:0] left_val,
  input  logic signed [slt_pkg::VAL_W-1:0] right_val,
  input  logic signed [slt_pkg::VAL_W-1:0] head_val,
  output logic signed [slt_pkg::VAL_W-1:0] val,
  output logic                            lt,
  output logic                            first,
  output logic                            hit
);
  import slt_pkg::*;

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  assign val   = val_r;
  assign lt    = occ && (val_r < key);
  assign first = !lt && left_lt;
  assign hit   = first && occ && (val_r == key);

  always_comb begin
    val_nxt = val_r;
    if (ctl.insert) begin
      if (first) begin
        val_nxt = key;
      end else if (!lt) begin
        val_nxt = left_val;
      end
    end else if (ctl.delete) begin
      if (ctl.found && !lt) begin
        val_nxt = right_val;
      end
    end else if (ctl.rotate) begin
      val_nxt = tail ? head_val : right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* rtl/core/sorted_list_table.sv */
// Sorted table of up to DEPTH signed 32-bit values, held in a row of cells
// that compare in parallel and shift entries toward their neighbors. An insert
// or delete keeps busy high for one cycle and gives its single result from
// the output registers, which follow the exec state. A full insert, a list of
// an empty table and an unused operation code do not raise busy; the first
// two give their result in the cycle after the transaction. A list keeps busy
// high while the row rotates once past the head cell, which streams one entry
// per cycle in ascending order with out_last on the final one. Every
// result is on the out_ ports for exactly one cycle with out_valid high, and
// the receiver cannot hold it off, so it must take each result as it comes.
module sorted_list_table #(
  parameter int DEPTH = slt_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_operation,
  input  logic signed [slt_pkg::VAL_W-1:0] in_value,
  output logic                            out_valid,
  output logic signed [slt_pkg::VAL_W-1:0] out_item_value,
  output logic [slt_pkg::POS_W-1:0]       out_position,
  output logic                            out_last,
  output logic [1:0]                      out_status
);
  import slt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LIST = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [1:0]              op_r, op_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;

  logic                    valid_r, valid_nxt;
  logic signed [VAL_W-1:0] item_r, item_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic                    last_r, last_nxt;
  logic [1:0]              status_r, status_nxt;

  slt_ctl_t                ctl;
  logic signed [VAL_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]        cell_lt;
  logic [DEPTH-1:0]        cell_first;
  logic [DEPTH-1:0]        cell_hit;
  logic [CW-1:0]           ins_pos;
  logic                    accept;
  logic [CW-1:0]           idx_inc;
  logic [CW+POS_W-1:0]     pos_ext;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign idx_inc = idx_r + CW'(1);

  assign ctl.insert = (state_r == S_EXEC) && (op_r == OP_INSERT);
  assign ctl.delete = (state_r == S_EXEC) && (op_r == OP_DELETE);
  assign ctl.found  = |cell_hit;
  assign ctl.rotate = (state_r == S_LIST);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_lt;
    logic signed [VAL_W-1:0] left_val;
    logic signed [VAL_W-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_lt  = 1'b1;
      assign left_val = key_r;
    end else begin : g_body
      assign left_lt  = cell_lt[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_val = cell_val[i];
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    slt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (CW'(i) < count_r),
      .tail      (CW'(i + 1) == count_r),
      .left_lt   (left_lt),
      .key       (key_r),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (cell_val[0]),
      .val       (cell_val[i]),
      .lt        (cell_lt[i]),
      .first     (cell_first[i]),
      .hit       (cell_hit[i])
    );
  end

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_first[i]) begin
        ins_pos = ins_pos | CW'(i + 1);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    valid_nxt  = 1'b0;
    item_nxt   = '0;
    pos_nxt    = '0;
    last_nxt   = 1'b1;
    status_nxt = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_operation;
          key_nxt = in_value;
          idx_nxt = '0;
          priority if (in_operation == OP_INSERT) begin
            if (count_r == CW'(DEPTH)) begin
              valid_nxt  = 1'b1;
              status_nxt = ST_FULL;
            end else begin
              state_nxt = S_EXEC;
            end
          end else if (in_operation == OP_DELETE) begin
            state_nxt = S_EXEC;
          end else if (in_operation == OP_LIST) begin
            if (count_r == '0) begin
              valid_nxt  = 1'b1;
              status_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_LIST;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EXEC: begin
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
        if (op_r == OP_INSERT) begin
          pos_nxt   = ins_pos;
          count_nxt = count_r + CW'(1);
        end else if (ctl.found) begin
          count_nxt = count_r - CW'(1);
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      S_LIST: begin
        valid_nxt = 1'b1;
        item_nxt  = cell_val[0];
        pos_nxt   = idx_inc;
        last_nxt  = (idx_inc == count_r);
        idx_nxt   = idx_inc;
        if (idx_inc == count_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    item_r   <= item_nxt;
    pos_r    <= pos_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
  end

  assign pos_ext        = {{POS_W{1'b0}}, pos_r};
  assign out_valid      = valid_r;
  assign out_item_value = item_r;
  assign out_position   = pos_ext[POS_W-1:0];
  assign out_last       = last_r;
  assign out_status     = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds the table depth");

  a_list_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |=> out_valid)
    else $error("list readout skipped a cycle");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && op_r == OP_INSERT) |=>
      (count_r == CW'($past(count_r) + CW'(1))))
    else $error("insert did not grow the table by one entry");

  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (state_r == S_LIST))
    else $error("non-final result outside a list readout");

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
    logic                    last;
    logic [1:0]              status;
  } table_result_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              in_operation = OP_INSERT;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_item_value;
  logic [POS_W-1:0]        out_position;
  logic                    out_last;
  logic [1:0]              out_status;

  logic signed [VAL_W-1:0] sorted_entries[$];
  table_result_t           pending_results[$];
  int                      mismatches = 0;
  bit                      sender_gaps = 1'b1;

  sorted_list_table uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_item_value (out_item_value),
    .out_position   (out_position),
    .out_last       (out_last),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("sorted_list_table regression: fail");
    $finish;
  end

  function automatic void push_result(logic signed [VAL_W-1:0] item, int pos, logic last,
                                      logic [1:0] status);
    table_result_t r;
    r.item_value = item;
    r.position   = POS_W'(pos);
    r.last       = last;
    r.status     = status;
    pending_results.push_back(r);
  endfunction

  function automatic void update_sorted_table(logic [1:0] op, logic signed [VAL_W-1:0] v);
    int idx;
    idx = 0;
    case (op)
      OP_INSERT: begin
        if (sorted_entries.size() >= DEPTH_DEF) begin
          push_result('0, 0, 1'b1, ST_FULL);
        end else begin
          while (idx < sorted_entries.size() && sorted_entries[idx] < v) idx++;
          sorted_entries.insert(idx, v);
          push_result('0, idx + 1, 1'b1, ST_OK);
        end
      end
      OP_DELETE: begin
        while (idx < sorted_entries.size() && sorted_entries[idx] != v) idx++;
        if (idx >= sorted_entries.size()) begin
          push_result('0, 0, 1'b1, ST_NOTFOUND);
        end else begin
          sorted_entries.delete(idx);
          push_result('0, 0, 1'b1, ST_OK);
        end
      end
      OP_LIST: begin
        if (sorted_entries.size() == 0) begin
          push_result('0, 0, 1'b1, ST_EMPTY);
        end else begin
          foreach (sorted_entries[i]) begin
            push_result(sorted_entries[i], i + 1, i == sorted_entries.size() - 1, ST_OK);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction waiting for it");
      end else begin
        want = pending_results.pop_front();
        if (out_item_value !== want.item_value)
          report_mismatch($sformatf("item_value %0d, wanted %0d", out_item_value,
                                    want.item_value));
        if (out_position !== want.position)
          report_mismatch($sformatf("position %0d, wanted %0d", out_position, want.position));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, wanted %0b", out_last, want.last));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", out_status, want.status));
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic signed [VAL_W-1:0] v);
    in_operation <= op;
    in_value     <= v;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    update_sorted_table(op, v);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $signed($urandom_range(0, 16)) - 8;
      1: v = $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: begin
        if (sorted_entries.size() == 0) v = $urandom;
        else v = sorted_entries[$urandom_range(0, sorted_entries.size() - 1)];
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_delete_value();
    if (sorted_entries.size() != 0 && $urandom_range(0, 9) < 7)
      return sorted_entries[$urandom_range(0, sorted_entries.size() - 1)];
    return pick_value();
  endfunction

  task automatic test_empty_table();
    send_item(OP_LIST, $urandom);
    send_item(OP_DELETE, '0);
    send_item(OP_UNUSED, $urandom);
    send_item(OP_LIST, '0);
  endtask

  task automatic test_extreme_values();
    send_item(OP_INSERT, 32'sh7fffffff);
    send_item(OP_INSERT, 32'sh80000000);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, -1);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, 32'sh80000000);
    send_item(OP_LIST, '0);
    send_item(OP_DELETE, 32'sh80000000);
    send_item(OP_DELETE, 32'sh7fffffff);
    send_item(OP_DELETE, 32'sd12345);
    send_item(OP_UNUSED, -1);
    send_item(OP_LIST, '0);
  endtask

  task automatic test_full_table();
    while (sorted_entries.size() < DEPTH_DEF) send_item(OP_INSERT, pick_value());
    send_item(OP_INSERT, $urandom);
    send_item(OP_INSERT, 32'sh80000000);
    send_item(OP_LIST, '0);
    wait_for_results();
    repeat (DEPTH_DEF / 2) send_item(OP_DELETE, pick_delete_value());
    send_item(OP_LIST, '0);
  endtask

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) send_item(OP_INSERT, pick_value());
    else if (pick < 75) send_item(OP_DELETE, pick_delete_value());
    else if (pick < 94) send_item(OP_LIST, $urandom);
    else send_item(OP_UNUSED, $urandom);
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < 110; n++) begin
      send_random_item();
      if (n == 55) wait_for_results();
    end
  endtask

  task automatic test_back_to_back();
    sender_gaps = 1'b0;
    repeat (25) send_random_item();
    send_item(OP_LIST, '0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_extreme_values();
    test_full_table();
    test_random_mix();
    test_back_to_back();
    wait_for_results();
    repeat (DEPTH_DEF + 4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("sorted_list_table regression: pass");
    end else begin
      $display("sorted_list_table regression: fail");
    end
    $finish;
  end

endmodule

/* sorted_list_table.f */
rtl/core/slt_pkg.sv
rtl/core/slt_cell.sv
rtl/core/sorted_list_table.sv
tb/testbench.sv
